// File: rtl/core/assert_macros.svh
// Assertion macros shared by the heap build core RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KMHB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kmhb assertion failed");

// Trigger in one cycle implies the result in the next cycle.
`define KMHB_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("kmhb assertion failed");

`endif

// File: rtl/core/kmhb_pkg.sv
// Package for the k-ary min-heap build core: sizes, state encoding,
// command and status structs. No dependencies.
`default_nettype none

package kmhb_pkg;

   localparam int ARITY    = 3;
   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;

   // index into the store, element count, child index and counters
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CH_W  = $clog2(ARITY * CAPACITY + 2);
   localparam int K_W   = $clog2(ARITY + 1);
   localparam int R_W   = $clog2(ARITY);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PREP,
      ST_NODE_RD,
      ST_NODE_CAP,
      ST_CHILD_RD,
      ST_CHILD_CMP,
      ST_DECIDE,
      ST_SWAP_B,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } kmhb_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic node_rd;
      logic node_cap;
      logic child_rd;
      logic child_cmp;
      logic swap_a;
      logic swap_b;
      logic next_outer;
      logic emit_rd;
      logic emit_out;
   } kmhb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_small;
      logic child_ok;
      logic node_best;
      logic outer_zero;
      logic emit_last;
   } kmhb_status_type;

endpackage

`default_nettype wire

// File: rtl/core/kmhb_ctrl.sv
// Sequencer for the heap build core: load, bottom-up sift-down, emit.
// Depends on kmhb_pkg.
`default_nettype none

module kmhb_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      req_last_in,
   input  wire kmhb_pkg::kmhb_status_type status,
   output kmhb_pkg::kmhb_cmd_type         cmd,
   output logic                           busy,
   output logic                           rsp_valid
);
   import kmhb_pkg::*;

   kmhb_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (start && req_last_in) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.count_small ? ST_EMIT_RD : ST_NODE_RD;
         end
         ST_NODE_RD:   state_in = ST_NODE_CAP;
         ST_NODE_CAP:  state_in = ST_CHILD_RD;
         ST_CHILD_RD: begin
            state_in = status.child_ok ? ST_CHILD_CMP : ST_DECIDE;
         end
         ST_CHILD_CMP: state_in = ST_CHILD_RD;
         ST_DECIDE: begin
            if (!status.node_best)      state_in = ST_SWAP_B;
            else if (status.outer_zero) state_in = ST_EMIT_RD;
            else                        state_in = ST_NODE_RD;
         end
         ST_SWAP_B:    state_in = ST_NODE_RD;
         ST_EMIT_RD:   state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            state_in = status.emit_last ? ST_LOAD : ST_EMIT_RD;
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   // command decode
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_PREP:      cmd.prep      = 1'b1;
         ST_NODE_RD:   cmd.node_rd   = 1'b1;
         ST_NODE_CAP:  cmd.node_cap  = 1'b1;
         ST_CHILD_RD:  cmd.child_rd  = status.child_ok;
         ST_CHILD_CMP: cmd.child_cmp = 1'b1;
         ST_DECIDE: begin
            cmd.swap_a     = !status.node_best;
            cmd.next_outer = status.node_best && !status.outer_zero;
         end
         ST_SWAP_B:    cmd.swap_b    = 1'b1;
         ST_EMIT_RD:   cmd.emit_rd   = 1'b1;
         ST_EMIT_OUT: begin
            cmd.emit_out = 1'b1;
            rsp_valid    = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/kmhb_dpath.sv
// Datapath for the heap build core: element store, sift-down registers,
// compare, load and emit counters. Depends on kmhb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kmhb_dpath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire kmhb_pkg::kmhb_cmd_type    cmd,
   input  wire logic signed [31:0]        req_element_value,
   output kmhb_pkg::kmhb_status_type      status,
   output logic signed [31:0]             rsp_heap_value,
   output logic                           rsp_last_out,
   output logic                           rsp_overflowed
);
   import kmhb_pkg::*;

   // element store, one write and one registered read port
   logic signed [DATA_W-1:0] mem [CAPACITY];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   // control registers
   logic [CNT_W-1:0] count_ff;
   logic             ovf_ff;
   logic [IDX_W-1:0] emit_ff;
   logic [IDX_W-1:0] par_ff;     // parent of the next index to store
   logic [R_W-1:0]   rem_ff;     // sibling position of the next index
   logic [IDX_W-1:0] start_ff;   // parent of the last stored index

   // sift-down registers
   logic [IDX_W-1:0]         outer_ff;
   logic [IDX_W-1:0]         cur_ff;
   logic [CH_W-1:0]          child_ff;
   logic [K_W-1:0]           k_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic signed [DATA_W-1:0] best_val_ff;
   logic signed [DATA_W-1:0] node_val_ff;

   logic room;
   logic child_less;

   assign room       = count_ff < CNT_W'(CAPACITY);
   assign child_less = rd_data_ff < best_val_ff;

   // status to the controller
   assign status.count_small = count_ff < CNT_W'(2);
   assign status.child_ok    = (child_ff < CH_W'(count_ff)) && (k_ff < K_W'(ARITY));
   assign status.node_best   = best_idx_ff == cur_ff;
   assign status.outer_zero  = outer_ff == '0;
   assign status.emit_last   = (CNT_W'(emit_ff) + CNT_W'(1)) == count_ff;

   // result fields
   assign rsp_heap_value = rd_data_ff;
   assign rsp_last_out   = status.emit_last;
   assign rsp_overflowed = ovf_ff;

   // read address select
   always_comb begin
      rd_en   = cmd.node_rd || cmd.child_rd || cmd.emit_rd;
      rd_addr = cur_ff;
      if (cmd.child_rd)     rd_addr = child_ff[IDX_W-1:0];
      else if (cmd.emit_rd) rd_addr = emit_ff;
   end

   // write address and data select
   always_comb begin
      wr_en   = (cmd.load && room) || cmd.swap_a || cmd.swap_b;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = req_element_value;
      if (cmd.swap_a) begin
         wr_addr = cur_ff;
         wr_data = best_val_ff;
      end else if (cmd.swap_b) begin
         wr_addr = best_idx_ff;
         wr_data = node_val_ff;
      end
   end

   // store
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // load count, overflow flag, parent tracking and emit index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         emit_ff  <= '0;
         par_ff   <= '0;
         rem_ff   <= '0;
      end else if (cmd.load) begin
         if (room) begin
            count_ff <= count_ff + CNT_W'(1);
            if (count_ff != '0) begin
               if (rem_ff == R_W'(ARITY - 1)) begin
                  rem_ff <= '0;
                  par_ff <= par_ff + IDX_W'(1);
               end else begin
                  rem_ff <= rem_ff + R_W'(1);
               end
            end
         end else begin
            ovf_ff <= 1'b1;
         end
      end else if (cmd.emit_out) begin
         if (status.emit_last) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
            emit_ff  <= '0;
            par_ff   <= '0;
            rem_ff   <= '0;
         end else begin
            emit_ff <= emit_ff + IDX_W'(1);
         end
      end
   end

   // last parent seen, taken as the first sift node
   always_ff @(posedge clock) begin
      if (cmd.load && room && count_ff != '0) start_ff <= par_ff;
   end

   // sift-down walk
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         outer_ff <= start_ff;
         cur_ff   <= start_ff;
      end
      if (cmd.next_outer) begin
         outer_ff <= outer_ff - IDX_W'(1);
         cur_ff   <= outer_ff - IDX_W'(1);
      end
      if (cmd.node_rd) begin
         child_ff <= CH_W'(cur_ff) * CH_W'(ARITY) + CH_W'(1);
         k_ff     <= '0;
      end
      if (cmd.node_cap) begin
         node_val_ff <= rd_data_ff;
         best_val_ff <= rd_data_ff;
         best_idx_ff <= cur_ff;
      end
      if (cmd.child_cmp) begin
         // strict less: equal children keep the lower index
         if (child_less) begin
            best_val_ff <= rd_data_ff;
            best_idx_ff <= child_ff[IDX_W-1:0];
         end
         child_ff <= child_ff + CH_W'(1);
         k_ff     <= k_ff + K_W'(1);
      end
      if (cmd.swap_b) cur_ff <= best_idx_ff;
   end

   // checks
   `KMHB_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `KMHB_ASSERT(a_swap_idx, clock, reset,
      !cmd.swap_a || (best_idx_ff > cur_ff && CNT_W'(best_idx_ff) < count_ff))
   `KMHB_ASSERT(a_emit_range, clock, reset, !cmd.emit_out || CNT_W'(emit_ff) < count_ff)
   `KMHB_ASSERT_NEXT(a_emit_clear, clock, reset, cmd.emit_out && status.emit_last,
      count_ff == '0 && !ovf_ff)

endmodule

`default_nettype wire

// File: rtl/core/kary_min_heap_build_core.sv
// Top level of the k-ary min-heap build core: controller plus datapath.
// Depends on kmhb_pkg, kmhb_ctrl and kmhb_dpath.
//
//   channel   handshake            payload
//   request   start / busy         req_element_value, req_last_in
//   response  rsp_valid (strobe)   rsp_heap_value, rsp_last_out, rsp_overflowed
//
// Loading takes one cycle per element; busy is low only while loading.
// After the last element: a prep step, then per sift step a node read and capture,
// a read and compare per child examined, a decide, and a swap step if one follows;
// bounded by the single store read port. Emission reads, then shows each element.
// Synchronous reset clears the count and overflow flag; the store needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module kary_min_heap_build_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_element_value,
   input  wire logic               req_last_in,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_heap_value,
   output logic                    rsp_last_out,
   output logic                    rsp_overflowed
);
   import kmhb_pkg::*;

   kmhb_cmd_type    cmd;
   kmhb_status_type status;

   kmhb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_last_in (req_last_in),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   kmhb_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_element_value (req_element_value),
      .status            (status),
      .rsp_heap_value    (rsp_heap_value),
      .rsp_last_out      (rsp_last_out),
      .rsp_overflowed    (rsp_overflowed)
   );

endmodule

`default_nettype wire
